[hdl/rlbe_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the run-length byte encoder.
// Used by the front end, the command queue, the back end and the top level.
package rlbe_pkg;

    localparam int BYTE_W      = 8;
    // Header counts reach at most 128, so eight bits cover every packet length.
    localparam int CNT_W       = 8;
    // Largest literal packet that the literal store can hold.
    localparam int LIT_DEPTH   = 32;
    localparam int LIT_CNT_W   = 6;
    // Literal byte queue: room for one open literal and one that is draining.
    localparam int LITQ_DEPTH  = 64;
    localparam int LITQ_AW     = 6;
    localparam int LITQ_CNT_W  = 7;
    // Command queue between the front and back ends.
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_AW     = 2;
    localparam int CMDQ_CNT_W  = 3;

    localparam logic [BYTE_W-1:0] LIT_FLAG = 8'h80;

    typedef enum logic {
        CMD_LIT,
        CMD_RUN
    } cmd_kind_t;

    // One packet to be written out by the back end.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] data;
        logic              done;
    } cmd_t;

endpackage

[hdl/run_length_byte_encoder_core.sv]
`timescale 1ns / 1ps
// Run-length byte encoder top level: front end, command and literal queues, back end.
// A packet's header passes the command queue, the back end's idle and header states
// and the output register after the transfer that closes it; the last packet of a
// stream also waits for a flush step in the front end. Throughput: one input byte per
// cycle while the queues have room, none during that flush. The back end writes one
// byte per cycle within a packet while the output is taken, and idles between packets.
// Reset: aresetn, synchronous and active low, empties both queues and the held run.
module run_length_byte_encoder_core #(
    parameter int MAX_PACKET = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rlbe_pkg::BYTE_W-1:0] s_tdata,   // data_byte [7:0]
    input  logic                        s_tlast,   // stream_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rlbe_pkg::BYTE_W-1:0] m_tdata,   // out_byte [7:0]
    output logic                        m_tlast,   // packet_end
    output logic [0:0]                  m_tuser    // stream_done [0]
);
    import rlbe_pkg::*;

    logic              lit_push;
    logic [BYTE_W-1:0] lit_data;
    logic              litq_full;
    logic              litq_pop;
    logic [BYTE_W-1:0] litq_rd_data;
    logic              cmd_push;
    cmd_t              cmd;
    logic              cmdq_full;
    logic              cmdq_pop;
    cmd_t              cmdq_head;
    logic              cmdq_valid;
    logic              done_bit;

    // Classifies input bytes into runs and literals.
    rlbe_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .litq_full (litq_full),
        .lit_push  (lit_push),
        .lit_data  (lit_data),
        .cmdq_full (cmdq_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    // Literal bytes waiting to be written out.
    rlbe_lit_fifo u_lit_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (lit_push),
        .push_data (lit_data),
        .pop       (litq_pop),
        .rd_data   (litq_rd_data),
        .full      (litq_full)
    );

    // Packet commands between the two halves.
    rlbe_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_cmd  (cmd),
        .pop       (cmdq_pop),
        .head      (cmdq_head),
        .not_empty (cmdq_valid),
        .full      (cmdq_full)
    );

    // Writes packets out one transfer at a time.
    rlbe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmdq_valid   (cmdq_valid),
        .cmdq_head    (cmdq_head),
        .cmdq_pop     (cmdq_pop),
        .litq_pop     (litq_pop),
        .litq_rd_data (litq_rd_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (done_bit)
    );

    assign m_tuser = done_bit;

endmodule

[hdl/rlbe_lit_fifo.sv]
`timescale 1ns / 1ps
// Literal byte queue: a simple dual-port memory with a registered read.
// Depends on rlbe_pkg for its depth and widths.
module rlbe_lit_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  logic [rlbe_pkg::BYTE_W-1:0] push_data,
    input  logic                      pop,
    output logic [rlbe_pkg::BYTE_W-1:0] rd_data,
    output logic                      full
);
    import rlbe_pkg::*;

    logic [BYTE_W-1:0]     mem [LITQ_DEPTH];
    logic [BYTE_W-1:0]     rd_data_reg;
    logic [LITQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [LITQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LITQ_CNT_W-1:0] fill_reg, fill_next;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage: one write and one registered read per cycle, no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign full    = (fill_reg == LITQ_CNT_W'(LITQ_DEPTH));

endmodule

[hdl/rlbe_cmd_fifo.sv]
`timescale 1ns / 1ps
// Short packet command queue between the front and back ends.
// Depends on rlbe_pkg for the command type and queue depth.
module rlbe_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rlbe_pkg::cmd_t push_cmd,
    input  logic           pop,
    output rlbe_pkg::cmd_t head,
    output logic           not_empty,
    output logic           full
);
    import rlbe_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] fill_reg, fill_next;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entries carry payload only and need no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg == CMDQ_CNT_W'(CMDQ_DEPTH));

endmodule

[hdl/rlbe_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks the current run and open literal,
// and issues packet commands and literal bytes. Depends on rlbe_pkg.
module rlbe_front #(
    parameter int MAX_PACKET = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rlbe_pkg::BYTE_W-1:0] s_tdata,
    input  logic                        s_tlast,
    input  logic                        litq_full,
    output logic                        lit_push,
    output logic [rlbe_pkg::BYTE_W-1:0] lit_data,
    input  logic                        cmdq_full,
    output logic                        cmd_push,
    output rlbe_pkg::cmd_t              cmd
);
    import rlbe_pkg::*;

    // A literal closes at the packet limit or when the store is full.
    localparam int LIT_LIMIT = (MAX_PACKET < LIT_DEPTH) ? MAX_PACKET : LIT_DEPTH;
    localparam logic [LIT_CNT_W-1:0] LIT_LIMIT_C = LIT_CNT_W'(LIT_LIMIT);
    localparam logic [CNT_W-1:0]     MAX_C       = CNT_W'(MAX_PACKET);

    typedef enum logic {
        ST_STEP,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic                   pend_reg, pend_next;
    logic [BYTE_W-1:0]      run_byte_reg, run_byte_next;
    logic [CNT_W-1:0]       run_cnt_reg, run_cnt_next;
    logic [LIT_CNT_W-1:0]   lit_cnt_reg, lit_cnt_next;
    logic [LIT_CNT_W-1:0]   lit_inc;
    logic                   room;
    logic                   accept;

    assign room     = !litq_full && !cmdq_full;
    assign s_tready = (state_reg == ST_STEP) && room;
    assign accept   = s_tvalid && s_tready;
    assign lit_inc  = lit_cnt_reg + 1'b1;
    assign lit_data = run_byte_reg;

    // Per-byte step, and a flush step at the end of a stream.
    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        run_byte_next = run_byte_reg;
        run_cnt_next  = run_cnt_reg;
        lit_cnt_next  = lit_cnt_reg;
        lit_push      = 1'b0;
        cmd_push      = 1'b0;
        cmd.kind      = CMD_LIT;
        cmd.count     = CNT_W'(lit_cnt_reg);
        cmd.data      = run_byte_reg;
        cmd.done      = 1'b0;

        if (accept) begin
            if (!pend_reg) begin
                run_byte_next = s_tdata;
                run_cnt_next  = CNT_W'(1);
                pend_next     = 1'b1;
            end else if (s_tdata == run_byte_reg) begin
                if (run_cnt_reg == CNT_W'(1)) begin
                    // A pair starts: close any open literal before it.
                    cmd_push     = (lit_cnt_reg != '0);
                    lit_cnt_next = '0;
                    run_cnt_next = CNT_W'(2);
                end else if (run_cnt_reg < MAX_C) begin
                    run_cnt_next = run_cnt_reg + 1'b1;
                end else begin
                    // Run at its maximum: emit it, this byte opens a new run.
                    cmd_push     = 1'b1;
                    cmd.kind     = CMD_RUN;
                    cmd.count    = run_cnt_reg;
                    run_cnt_next = CNT_W'(1);
                end
            end else begin
                if (run_cnt_reg >= CNT_W'(2)) begin
                    cmd_push  = 1'b1;
                    cmd.kind  = CMD_RUN;
                    cmd.count = run_cnt_reg;
                end else begin
                    // Lone byte joins the literal; a full literal goes out at once.
                    lit_push     = 1'b1;
                    lit_cnt_next = lit_inc;
                    if (lit_inc >= LIT_LIMIT_C) begin
                        cmd_push     = 1'b1;
                        cmd.count    = CNT_W'(lit_inc);
                        lit_cnt_next = '0;
                    end
                end
                run_byte_next = s_tdata;
                run_cnt_next  = CNT_W'(1);
            end
            if (s_tlast) begin
                state_next = ST_FINISH;
            end
        end else if (state_reg == ST_FINISH && room) begin
            // While a run of two or more is held the literal is always empty.
            cmd_push = 1'b1;
            cmd.done = 1'b1;
            if (run_cnt_reg >= CNT_W'(2)) begin
                cmd.kind  = CMD_RUN;
                cmd.count = run_cnt_reg;
            end else begin
                lit_push  = 1'b1;
                cmd.count = CNT_W'(lit_inc);
            end
            pend_next     = 1'b0;
            run_byte_next = '0;
            run_cnt_next  = '0;
            lit_cnt_next  = '0;
            state_next    = ST_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_STEP;
            pend_reg     <= 1'b0;
            run_byte_reg <= '0;
            run_cnt_reg  <= '0;
            lit_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            run_byte_reg <= run_byte_next;
            run_cnt_reg  <= run_cnt_next;
            lit_cnt_reg  <= lit_cnt_next;
        end
    end

endmodule

[hdl/rlbe_back.sv]
`timescale 1ns / 1ps
// Back end: takes packet commands and writes header and data bytes into
// the output register. Depends on rlbe_pkg for the command type.
module rlbe_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmdq_valid,
    input  rlbe_pkg::cmd_t              cmdq_head,
    output logic                        cmdq_pop,
    output logic                        litq_pop,
    input  logic [rlbe_pkg::BYTE_W-1:0] litq_rd_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rlbe_pkg::BYTE_W-1:0] m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);
    import rlbe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_RUN,
        ST_LIT
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [LIT_CNT_W-1:0]   rem_reg, rem_next;
    logic                   valid_reg, valid_next;
    logic [BYTE_W-1:0]      data_reg, data_next;
    logic                   last_reg, last_next;
    logic                   user_reg, user_next;
    logic                   free;
    logic [BYTE_W-1:0]      hdr;

    assign free = !valid_reg || m_tready;
    assign hdr  = (cmd_reg.kind == CMD_LIT) ? ((cmd_reg.count - 1'b1) | LIT_FLAG)
                                            : (cmd_reg.count - 1'b1);

    // Packet sequencer; rem counts literal bytes still to be read.
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        cmdq_pop   = 1'b0;
        litq_pop   = 1'b0;

        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmdq_valid) begin
                    cmdq_pop   = 1'b1;
                    cmd_next   = cmdq_head;
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                if (free) begin
                    valid_next = 1'b1;
                    data_next  = hdr;
                    last_next  = 1'b0;
                    user_next  = 1'b0;
                    if (cmd_reg.kind == CMD_RUN) begin
                        state_next = ST_RUN;
                    end else begin
                        // Fetch the first literal byte alongside the header.
                        litq_pop   = 1'b1;
                        rem_next   = LIT_CNT_W'(cmd_reg.count - 1'b1);
                        state_next = ST_LIT;
                    end
                end
            end
            ST_RUN: begin
                if (free) begin
                    valid_next = 1'b1;
                    data_next  = cmd_reg.data;
                    last_next  = 1'b1;
                    user_next  = cmd_reg.done;
                    state_next = ST_IDLE;
                end
            end
            ST_LIT: begin
                if (free) begin
                    valid_next = 1'b1;
                    data_next  = litq_rd_data;
                    last_next  = (rem_reg == '0);
                    user_next  = (rem_reg == '0) && cmd_reg.done;
                    if (rem_reg != '0) begin
                        litq_pop = 1'b1;
                        rem_next = rem_reg - 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        cmd_reg  <= cmd_next;
        rem_reg  <= rem_next;
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule
